// ----- rtl/core/complex_arith_unit_assert.svh -----
// assertion helpers for the complex arithmetic unit checker
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define CAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/cau_pkg.sv -----
package cau_pkg;

  localparam int DW   = 16;
  localparam int FB   = 8;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int DENW = PW;
  localparam int MW   = ((SW + FB) > DENW ? (SW + FB) : DENW) + 1;
  localparam int RW   = (MW > (DENW + DW) ? MW : (DENW + DW)) + 1;

  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]           command;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 overflow;
    logic                 div_by_zero;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] v;
    logic          o;
  } sat_t;

  // sign and magnitude to saturated two's complement
  function automatic sat_t sat_mag(input logic neg, input logic [RW-1:0] mag);
    sat_t          r;
    logic [RW-1:0] lim;
    lim = neg ? (RW'(1) << (DW - 1)) : ((RW'(1) << (DW - 1)) - RW'(1));
    if (mag > lim) begin
      r.o = 1'b1;
      r.v = neg ? DMIN : DMAX;
    end else begin
      r.o = 1'b0;
      r.v = neg ? (~mag[DW-1:0] + 1'b1) : mag[DW-1:0];
    end
    return r;
  endfunction

  function automatic sat_t sat_signed(input logic signed [RW-1:0] v);
    logic [RW-1:0] mag;
    mag = v[RW-1] ? RW'(-v) : RW'(v);
    return sat_mag(v[RW-1], mag);
  endfunction

endpackage

// ----- rtl/core/complex_arith_unit.sv -----
// Complex add, subtract, multiply, divide and negate on signed Q8.8 operands, one request
// per cycle with no bubbles while in_stall is low. Every request passes through 21 register
// stages before its result appears at the outputs: three stages form the products, sums
// and rounding, a staging register feeds a restoring divider of one quotient bit per stage
// (16 stages) that runs for every request, and the output register takes the saturated
// result. The pipeline advances as a whole; in_stall rises only while a result is held at
// the output by out_stall. Results round to nearest (ties away from zero), saturate to 16
// bits with overflow set, and a zero divisor gives zero with div_by_zero set.
module complex_arith_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cau_pkg::out_t out_data
);

  localparam int DW   = cau_pkg::DW;
  localparam int FB   = cau_pkg::FB;
  localparam int PW   = cau_pkg::PW;
  localparam int SW   = cau_pkg::SW;
  localparam int DENW = cau_pkg::DENW;
  localparam int MW   = cau_pkg::MW;
  localparam int RW   = cau_pkg::RW;
  localparam logic [RW-1:0] HALF = (RW'(1) << FB) >> 1;

  typedef struct packed {
    logic             v;
    logic             is_div;
    logic             negx;
    logic             negy;
    logic             bigx;
    logic             bigy;
    logic [RW-1:0]    remx;
    logic [RW-1:0]    remy;
    logic [DW-1:0]    qx;
    logic [DW-1:0]    qy;
    logic [DENW-1:0]  den;
    cau_pkg::out_t    res;
  } dstg_t;

  function automatic dstg_t div_step(input dstg_t s, input int k);
    dstg_t         r;
    logic [RW-1:0] t;
    r = s;
    t = RW'(s.den) << k;
    if (s.remx >= t) begin
      r.remx  = s.remx - t;
      r.qx[k] = 1'b1;
    end
    if (s.remy >= t) begin
      r.remy  = s.remy - t;
      r.qy[k] = 1'b1;
    end
    return r;
  endfunction

  logic adv;
  logic out_valid_r;
  cau_pkg::out_t out_r, out_nxt;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: products and simple ops
  logic                   v1_r;
  logic [2:0]             cmd1_r;
  logic signed [PW-1:0]   p_rr_r, p_ii_r, p_ri_r, p_ir_r, d_r_r, d_i_r;
  logic signed [DW:0]     smp_re1_r, smp_im1_r, smp_re_nxt, smp_im_nxt;

  always_comb begin
    smp_re_nxt = '0;
    smp_im_nxt = '0;
    case (in_data.command)
      cau_pkg::CMD_ADD: begin
        smp_re_nxt = (DW+1)'(in_data.a_re) + (DW+1)'(in_data.b_re);
        smp_im_nxt = (DW+1)'(in_data.a_im) + (DW+1)'(in_data.b_im);
      end
      cau_pkg::CMD_SUB: begin
        smp_re_nxt = (DW+1)'(in_data.a_re) - (DW+1)'(in_data.b_re);
        smp_im_nxt = (DW+1)'(in_data.a_im) - (DW+1)'(in_data.b_im);
      end
      cau_pkg::CMD_NEG: begin
        smp_re_nxt = -(DW+1)'(in_data.a_re);
        smp_im_nxt = -(DW+1)'(in_data.a_im);
      end
      default: begin
        smp_re_nxt = '0;
        smp_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r    <= in_data.command;
      p_rr_r    <= PW'(in_data.a_re * in_data.b_re);
      p_ii_r    <= PW'(in_data.a_im * in_data.b_im);
      p_ri_r    <= PW'(in_data.a_re * in_data.b_im);
      p_ir_r    <= PW'(in_data.a_im * in_data.b_re);
      d_r_r     <= PW'(in_data.b_re * in_data.b_re);
      d_i_r     <= PW'(in_data.b_im * in_data.b_im);
      smp_re1_r <= smp_re_nxt;
      smp_im1_r <= smp_im_nxt;
    end
  end

  // stage 2: product sums and divisor
  logic                 v2_r;
  logic [2:0]           cmd2_r;
  logic signed [SW-1:0] x2_r, y2_r, x2_nxt, y2_nxt;
  logic [DENW-1:0]      den2_r;
  cau_pkg::out_t        res2_r, res2_nxt;
  cau_pkg::sat_t        sr2, si2;

  always_comb begin
    if (cmd1_r == cau_pkg::CMD_MUL) begin
      x2_nxt = SW'(p_rr_r) - SW'(p_ii_r);
      y2_nxt = SW'(p_ri_r) + SW'(p_ir_r);
    end else begin
      x2_nxt = SW'(p_rr_r) + SW'(p_ii_r);
      y2_nxt = SW'(p_ir_r) - SW'(p_ri_r);
    end
    sr2 = cau_pkg::sat_signed(RW'(smp_re1_r));
    si2 = cau_pkg::sat_signed(RW'(smp_im1_r));
    res2_nxt.res_re      = sr2.v;
    res2_nxt.res_im      = si2.v;
    res2_nxt.overflow    = sr2.o | si2.o;
    res2_nxt.div_by_zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r <= cmd1_r;
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      den2_r <= DENW'(d_r_r) + DENW'(d_i_r);
      res2_r <= res2_nxt;
    end
  end

  // stage 3: magnitudes, multiply rounding, divider operands
  logic                 v3_r, is_div3_r, negx3_r, negy3_r;
  logic [MW-1:0]        mx3_r, my3_r;
  logic [DENW-1:0]      den3_r;
  cau_pkg::out_t        res3_r, res3_nxt;
  logic signed [RW-1:0] xw, yw;
  logic [RW-1:0]        magx, magy;
  cau_pkg::sat_t        sr3, si3;
  logic                 dz3;

  always_comb begin
    xw   = RW'(x2_r);
    yw   = RW'(y2_r);
    magx = xw[RW-1] ? RW'(-xw) : RW'(xw);
    magy = yw[RW-1] ? RW'(-yw) : RW'(yw);
    sr3  = cau_pkg::sat_mag(xw[RW-1], (magx + HALF) >> FB);
    si3  = cau_pkg::sat_mag(yw[RW-1], (magy + HALF) >> FB);
    dz3  = (den2_r == '0);
    res3_nxt = res2_r;
    if (cmd2_r == cau_pkg::CMD_MUL) begin
      res3_nxt.res_re   = sr3.v;
      res3_nxt.res_im   = si3.v;
      res3_nxt.overflow = sr3.o | si3.o;
    end else if (cmd2_r == cau_pkg::CMD_DIV) begin
      res3_nxt = '0;
      res3_nxt.div_by_zero = dz3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      is_div3_r <= (cmd2_r == cau_pkg::CMD_DIV) && !dz3;
      negx3_r   <= xw[RW-1];
      negy3_r   <= yw[RW-1];
      // rounding bias: half the divisor
      mx3_r     <= MW'(magx << FB) + MW'(den2_r >> 1);
      my3_r     <= MW'(magy << FB) + MW'(den2_r >> 1);
      den3_r    <= den2_r;
      res3_r    <= res3_nxt;
    end
  end

  // divider stages, one quotient bit each
  dstg_t st_r [0:DW];
  dstg_t st0_nxt;

  always_comb begin
    st0_nxt        = '0;
    st0_nxt.v      = v3_r;
    st0_nxt.is_div = is_div3_r;
    st0_nxt.negx   = negx3_r;
    st0_nxt.negy   = negy3_r;
    st0_nxt.bigx   = RW'(mx3_r) >= (RW'(den3_r) << DW);
    st0_nxt.bigy   = RW'(my3_r) >= (RW'(den3_r) << DW);
    st0_nxt.remx   = RW'(mx3_r);
    st0_nxt.remy   = RW'(my3_r);
    st0_nxt.den    = den3_r;
    st0_nxt.res    = res3_r;
  end

  // only the valid bits of the divider stages are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= DW; j++) begin
        st_r[j].v <= 1'b0;
      end
    end else if (adv) begin
      st_r[0] <= st0_nxt;
      for (int j = 0; j < DW; j++) begin
        st_r[j+1] <= div_step(st_r[j], DW - 1 - j);
      end
    end
  end

  // final saturation
  cau_pkg::sat_t sqx, sqy;

  always_comb begin
    sqx = cau_pkg::sat_mag(st_r[DW].negx,
                           st_r[DW].bigx ? (RW'(1) << DW) : RW'(st_r[DW].qx));
    sqy = cau_pkg::sat_mag(st_r[DW].negy,
                           st_r[DW].bigy ? (RW'(1) << DW) : RW'(st_r[DW].qy));
    out_nxt = st_r[DW].res;
    if (st_r[DW].is_div) begin
      out_nxt.res_re      = sqx.v;
      out_nxt.res_im      = sqy.v;
      out_nxt.overflow    = sqx.o | sqy.o;
      out_nxt.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= st_r[DW].v;
    end
  end

endmodule

// ----- rtl/core/cau_checker.sv -----
`include "complex_arith_unit_assert.svh"

module cau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input cau_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cau_pkg::out_t out_data
);

  logic dz_clean;
  logic ovf_at_limit;

  assign dz_clean = out_data.res_re == '0 && out_data.res_im == '0 && !out_data.overflow;
  assign ovf_at_limit = out_data.res_re == cau_pkg::DMAX || out_data.res_re == cau_pkg::DMIN ||
                        out_data.res_im == cau_pkg::DMAX || out_data.res_im == cau_pkg::DMIN;

  `CAU_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  `CAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  `CAU_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  `CAU_ASSERT_NOW(a_dz_zero, out_valid && out_data.div_by_zero, dz_clean)

  `CAU_ASSERT_NOW(a_ovf_limit, out_valid && out_data.overflow, ovf_at_limit)

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
